FILE: hw/rtl/stc_pkg.sv
// Types and constants shared by the source character tokenizer.
package stc_pkg;

	localparam int TEXT_CHARS = 8;
	localparam int TEXT_BITS  = 8 * TEXT_CHARS;
	localparam logic [63:0] TEXT_MASK = (64'd1 << TEXT_BITS) - 64'd1;

	localparam logic [7:0]  LEN_MAX       = 8'd255;
	localparam logic [7:0]  TEXT_CHARS_LEN = 8'(TEXT_CHARS);
	localparam logic [7:0]  KEPT_BYTES    = 8'd8;

	localparam logic [63:0] KW_EXIT_TEXT = 64'h0000_0000_7469_7865;
	localparam logic [63:0] KW_INT_TEXT  = 64'h0000_0000_0074_6E69;
	localparam logic [7:0]  KW_EXIT_LEN  = 8'd4;
	localparam logic [7:0]  KW_INT_LEN   = 8'd3;

	localparam logic [7:0] CH_DIGIT_LO = 8'h30;
	localparam logic [7:0] CH_DIGIT_HI = 8'h39;
	localparam logic [7:0] CH_UPPER_LO = 8'h41;
	localparam logic [7:0] CH_UPPER_HI = 8'h5A;
	localparam logic [7:0] CH_LOWER_LO = 8'h61;
	localparam logic [7:0] CH_LOWER_HI = 8'h7A;
	localparam logic [7:0] CH_UNDER    = 8'h5F;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_EQUALS   = 8'h3D;
	localparam logic [7:0] CH_SEMI     = 8'h3B;

	typedef enum logic [3:0] {
		KIND_INTLIT = 4'd0,
		KIND_IDENT  = 4'd1,
		KIND_EXIT   = 4'd2,
		KIND_INT    = 4'd3,
		KIND_LPAREN = 4'd4,
		KIND_RPAREN = 4'd5,
		KIND_EQUALS = 4'd6,
		KIND_SEMI   = 4'd7,
		KIND_END    = 4'd8
	} tok_kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NUMBER = 2'd1,
		MODE_IDENT  = 2'd2
	} scan_mode_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [7:0]  length;
		logic [63:0] text;
		logic        cut;
		logic        last;
	} token_t;

	// Up to two tokens finished by one input beat, in order.
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} scan_out_t;

endpackage

FILE: hw/rtl/stc_if.sv
// Handshake channels of the tokenizer: source bytes in, tokens out.
interface stc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_input;

	modport source (output valid, output in_char, output end_of_input, input ready);
	modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface

interface stc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [7:0]  token_length;
	logic [63:0] token_text;
	logic        text_cut;
	logic        last;

	modport source (output valid, output token_kind, output token_length,
		output token_text, output text_cut, output last, input ready);
	modport sink (input valid, input token_kind, input token_length,
		input token_text, input text_cut, input last, output ready);
endinterface

FILE: hw/rtl/source_char_tokenizer.sv
// Top level of the byte-serial source tokenizer.
//
// chars: one source byte per beat (in_char), or an end-of-input marker
//   (end_of_input = 1, in_char ignored). Digit runs give integer literals,
//   letters open identifiers (exit and int become keywords), ( ) = ; give
//   single-byte tokens, other bytes only end the pending token.
// tokens: finished tokens with kind, saturating length, the first TEXT_CHARS
//   bytes of text, a cut flag, and last on the final token a beat caused.
//   A beat gives zero, one or two tokens; end of input gives the pending
//   token, if any, then an end token.
// Path: a beat taken on chars passes the input register, then the scan logic
//   writes the tokens it ends into a token queue that drives tokens.
// Throughput: one byte per cycle while the four-entry token queue has room
//   for two tokens, its condition to take a beat; beats that finish two
//   tokens back to back slow intake to the one token per cycle it drains.
// Reset (arst_n low) empties the queue and the input register and returns
//   the scanner to idle with no pending token.
// A stalled receiver fills the queue; chars.ready then drops until tokens
//   are taken. No token is lost or repeated.
module source_char_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	stc_in_if.sink     chars,
	stc_out_if.source  tokens
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;
	logic       room;
	logic       advance;

	stc_pkg::scan_out_t scan_res;

	assign advance     = valid_s1 && room;
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.in_char;
			eoi_s1  <= chars.end_of_input;
		end
	end

	stc_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.in_char      (char_s1),
		.end_of_input (eoi_s1),
		.res          (scan_res)
	);

	stc_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.wr     (scan_res),
		.room   (room),
		.tokens (tokens)
	);

endmodule

FILE: hw/rtl/stc_scan.sv
// Scanner state and the per-beat token decision logic.
module stc_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            in_char,
	input  logic                  end_of_input,
	output stc_pkg::scan_out_t    res
);

	stc_pkg::scan_mode_t mode_q, mode_d;
	logic [7:0]          len_q, len_d;
	logic [63:0]         text_q, text_d;

	logic               is_digit, is_letter, extend, pending;
	logic               has_second;
	stc_pkg::tok_kind_t pend_kind, punct_kind;
	logic               is_punct;
	stc_pkg::token_t    pend_tok, second_tok;
	logic [63:0]        append_text;

	always_comb begin
		is_digit  = (in_char >= stc_pkg::CH_DIGIT_LO) && (in_char <= stc_pkg::CH_DIGIT_HI);
		is_letter = ((in_char >= stc_pkg::CH_UPPER_LO) && (in_char <= stc_pkg::CH_UPPER_HI))
			|| ((in_char >= stc_pkg::CH_LOWER_LO) && (in_char <= stc_pkg::CH_LOWER_HI));
		pending   = (mode_q == stc_pkg::MODE_NUMBER) || (mode_q == stc_pkg::MODE_IDENT);
		extend    = !end_of_input
			&& (((mode_q == stc_pkg::MODE_NUMBER) && is_digit)
			|| ((mode_q == stc_pkg::MODE_IDENT)
				&& (is_letter || is_digit || (in_char == stc_pkg::CH_UNDER))));

		if (mode_q == stc_pkg::MODE_NUMBER) begin
			pend_kind = stc_pkg::KIND_INTLIT;
		end else if ((len_q == stc_pkg::KW_EXIT_LEN) && (text_q == stc_pkg::KW_EXIT_TEXT)) begin
			pend_kind = stc_pkg::KIND_EXIT;
		end else if ((len_q == stc_pkg::KW_INT_LEN) && (text_q == stc_pkg::KW_INT_TEXT)) begin
			pend_kind = stc_pkg::KIND_INT;
		end else begin
			pend_kind = stc_pkg::KIND_IDENT;
		end

		is_punct   = 1'b1;
		punct_kind = stc_pkg::KIND_SEMI;
		unique case (in_char)
			stc_pkg::CH_LPAREN: punct_kind = stc_pkg::KIND_LPAREN;
			stc_pkg::CH_RPAREN: punct_kind = stc_pkg::KIND_RPAREN;
			stc_pkg::CH_EQUALS: punct_kind = stc_pkg::KIND_EQUALS;
			stc_pkg::CH_SEMI:   punct_kind = stc_pkg::KIND_SEMI;
			default:            is_punct = 1'b0;
		endcase

		pend_tok.kind   = pend_kind;
		pend_tok.length = len_q;
		pend_tok.text   = text_q & stc_pkg::TEXT_MASK;
		pend_tok.cut    = len_q > stc_pkg::TEXT_CHARS_LEN;
		pend_tok.last   = 1'b0;

		has_second = end_of_input || is_punct;
		if (end_of_input) begin
			second_tok.kind   = stc_pkg::KIND_END;
			second_tok.length = 8'd0;
			second_tok.text   = 64'd0;
			second_tok.cut    = 1'b0;
		end else begin
			second_tok.kind   = punct_kind;
			second_tok.length = 8'd1;
			second_tok.text   = {56'd0, in_char} & stc_pkg::TEXT_MASK;
			second_tok.cut    = 8'd1 > stc_pkg::TEXT_CHARS_LEN;
		end
		second_tok.last = 1'b1;

		res.tok0  = second_tok;
		res.tok1  = second_tok;
		res.count = 2'd0;
		if (!extend && pending) begin
			res.tok0      = pend_tok;
			res.tok0.last = !has_second;
			res.count     = has_second ? 2'd2 : 2'd1;
		end else if (!extend && has_second) begin
			res.count = 2'd1;
		end

		append_text = text_q;
		if (len_q < stc_pkg::KEPT_BYTES) begin
			append_text = text_q | ({56'd0, in_char} << {len_q[2:0], 3'b000});
		end

		if (extend) begin
			mode_d = mode_q;
			len_d  = (len_q == stc_pkg::LEN_MAX) ? len_q : len_q + 8'd1;
			text_d = append_text;
		end else if (!end_of_input && is_digit) begin
			mode_d = stc_pkg::MODE_NUMBER;
			len_d  = 8'd1;
			text_d = {56'd0, in_char};
		end else if (!end_of_input && is_letter) begin
			mode_d = stc_pkg::MODE_IDENT;
			len_d  = 8'd1;
			text_d = {56'd0, in_char};
		end else begin
			mode_d = stc_pkg::MODE_IDLE;
			len_d  = 8'd0;
			text_d = 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stc_pkg::MODE_IDLE;
			len_q  <= 8'd0;
			text_q <= 64'd0;
		end else if (fire) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			text_q <= text_d;
		end
	end

endmodule

FILE: hw/rtl/stc_result_fifo.sv
// Four-entry token queue: up to two writes and one read per cycle.
module stc_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  stc_pkg::scan_out_t wr,
	output logic               room,
	stc_out_if.source          tokens
);

	stc_pkg::token_t mem [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] n_push;
	logic [1:0] wr_ptr_next;

	assign room        = count_q <= 3'd2;
	assign pop         = tokens.valid && tokens.ready;
	assign n_push      = push ? wr.count : 2'd0;
	assign wr_ptr_next = wr_ptr_q + 2'd1;

	assign tokens.valid        = count_q != 3'd0;
	assign tokens.token_kind   = mem[rd_ptr_q].kind;
	assign tokens.token_length = mem[rd_ptr_q].length;
	assign tokens.token_text   = mem[rd_ptr_q].text;
	assign tokens.text_cut     = mem[rd_ptr_q].cut;
	assign tokens.last         = mem[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem[wr_ptr_q] <= wr.tok0;
		end
		if (n_push == 2'd2) begin
			mem[wr_ptr_next] <= wr.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, n_push} - {2'd0, pop};
		end
	end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for source_char_tokenizer: directed and random byte streams checked against a token predictor.
module tb_top;
	import stc_pkg::*;

	localparam int RANDOM_BEATS = 1050;
	localparam int CALM_TAIL    = 120;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
	} src_beat_t;

	logic clk;
	logic arst_n;

	stc_in_if  src_if ();
	stc_out_if tok_if ();

	source_char_tokenizer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (src_if),
		.tokens (tok_if)
	);

	src_beat_t   beat_plan[$];
	token_t      tok_expect[$];
	src_beat_t   next_beat;
	scan_mode_t  scan_state;
	logic [7:0]  pend_len;
	logic [63:0] pend_text;
	int unsigned beats_taken;
	int unsigned send_gap;
	int unsigned take_gap;
	int unsigned hold_left;
	logic        hold_done;
	logic        holding;
	logic        calm;
	int unsigned bad_tokens;
	int unsigned tok_seen;
	int unsigned cycle_count = 0;

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= CH_LOWER_LO && c <= CH_LOWER_HI) || (c >= CH_UPPER_LO && c <= CH_UPPER_HI);
	endfunction

	function automatic token_t make_tok(input tok_kind_t k, input logic [7:0] len,
		input logic [63:0] text);
		token_t t;
		t.kind   = k;
		t.length = len;
		t.text   = text & TEXT_MASK;
		t.cut    = len > TEXT_CHARS_LEN;
		t.last   = 1'b0;
		return t;
	endfunction

	// Ends the pending token; returns 1 if there was one.
	function automatic bit close_token(output token_t t);
		tok_kind_t k;
		bit        found;
		found = 1'b1;
		k = KIND_INTLIT;
		if (scan_state == MODE_IDENT) begin
			if (pend_len == KW_EXIT_LEN && pend_text == KW_EXIT_TEXT)
				k = KIND_EXIT;
			else if (pend_len == KW_INT_LEN && pend_text == KW_INT_TEXT)
				k = KIND_INT;
			else
				k = KIND_IDENT;
		end else if (scan_state != MODE_NUMBER) begin
			found = 1'b0;
		end
		t = make_tok(k, pend_len, pend_text);
		scan_state = MODE_IDLE;
		pend_len   = '0;
		pend_text  = '0;
		return found;
	endfunction

	task automatic scan_byte(input logic [7:0] c, input logic eoi);
		token_t    fresh[$];
		token_t    t;
		tok_kind_t pk;
		bit        punct;
		if (eoi) begin
			if (close_token(t))
				fresh.push_back(t);
			fresh.push_back(make_tok(KIND_END, 8'd0, 64'd0));
		end else if ((scan_state == MODE_NUMBER && is_digit(c)) ||
			(scan_state == MODE_IDENT && (is_letter(c) || is_digit(c) || c == CH_UNDER))) begin
			if (pend_len < KEPT_BYTES)
				pend_text |= 64'(c) << (8 * pend_len);
			if (pend_len != LEN_MAX)
				pend_len++;
		end else begin
			if (close_token(t))
				fresh.push_back(t);
			if (is_digit(c) || is_letter(c)) begin
				scan_state = is_digit(c) ? MODE_NUMBER : MODE_IDENT;
				pend_len   = 8'd1;
				pend_text  = 64'(c);
			end else begin
				punct = 1'b1;
				pk = KIND_LPAREN;
				case (c)
					CH_LPAREN: pk = KIND_LPAREN;
					CH_RPAREN: pk = KIND_RPAREN;
					CH_EQUALS: pk = KIND_EQUALS;
					CH_SEMI:   pk = KIND_SEMI;
					default:   punct = 1'b0;
				endcase
				if (punct)
					fresh.push_back(make_tok(pk, 8'd1, 64'(c)));
			end
		end
		if (fresh.size() > 0)
			fresh[fresh.size() - 1].last = 1'b1;
		foreach (fresh[i])
			tok_expect.push_back(fresh[i]);
	endtask

	task automatic push_char(input logic [7:0] c);
		src_beat_t b;
		b.ch  = c;
		b.eoi = 1'b0;
		beat_plan.push_back(b);
	endtask

	task automatic push_eoi();
		src_beat_t b;
		b.ch  = 8'($urandom_range(0, 255));
		b.eoi = 1'b1;
		beat_plan.push_back(b);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? CH_LOWER_LO + 8'(r) : CH_UPPER_LO + 8'(r - 26);
	endfunction

	function automatic logic [7:0] rand_word_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 52)
			return rand_letter();
		else if (r < 62)
			return CH_DIGIT_LO + 8'(r - 52);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_DIGIT_LO + 8'($urandom_range(0, 9));
	endfunction

	task automatic push_word(input bit number, input int n);
		push_char(number ? rand_digit() : rand_letter());
		for (int i = 1; i < n; i++)
			push_char(number ? rand_digit() : rand_word_char());
	endtask

	task automatic plan_directed();
		push_text("exit(");
		push_text("int=");
		push_text("Az_09)");
		push_text("123456789;");
		push_char(8'h00);
		push_char(8'hFF);
		push_text("z");
		push_eoi();
		push_eoi();
	endtask

	task automatic plan_random();
		int base;
		int tok_no;
		int r;
		int n;
		base = beat_plan.size();
		tok_no = 0;
		while (beat_plan.size() - base < RANDOM_BEATS) begin
			r = $urandom_range(0, 99);
			if (tok_no == 40 || tok_no == 150) begin
				n = $urandom_range(250, 300);
				push_char(" ");
				push_word(tok_no == 150, n);
			end else if (r < 8) begin
				if (r[0])
					push_text("exit");
				else
					push_text("int");
				if ($urandom_range(0, 9) < 3)
					push_char(rand_word_char());
			end else if (r < 30) begin
				push_word(1'b0, $urandom_range(1, 12));
			end else if (r < 48) begin
				push_word(1'b1, $urandom_range(1, 12));
			end else if (r < 65) begin
				case ($urandom_range(0, 3))
					0: push_char(CH_LPAREN);
					1: push_char(CH_RPAREN);
					2: push_char(CH_EQUALS);
					default: push_char(CH_SEMI);
				endcase
			end else if (r < 82) begin
				case ($urandom_range(0, 2))
					0: push_char(" ");
					1: push_char(8'h09);
					default: push_char(8'h0A);
				endcase
			end else if (r < 96) begin
				push_char(8'($urandom_range(0, 255)));
			end else begin
				push_eoi();
			end
			tok_no++;
		end
		push_eoi();
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_if.valid        <= 1'b0;
			src_if.in_char      <= '0;
			src_if.end_of_input <= 1'b0;
			beats_taken         <= 0;
			calm                <= 1'b0;
			send_gap = 0;
		end else if (!src_if.valid || src_if.ready) begin
			if (src_if.valid) begin
				scan_byte(src_if.in_char, src_if.end_of_input);
				beats_taken <= beats_taken + 1;
			end
			if (send_gap == 0 && !calm && !holding && $urandom_range(0, 9) == 0)
				send_gap = $urandom_range(1, 17);
			if (send_gap > 0 || beat_plan.size() == 0) begin
				if (send_gap > 0)
					send_gap--;
				src_if.valid <= 1'b0;
			end else begin
				next_beat = beat_plan.pop_front();
				src_if.valid        <= 1'b1;
				src_if.in_char      <= next_beat.ch;
				src_if.end_of_input <= next_beat.eoi;
			end
			calm <= beat_plan.size() < CALM_TAIL;
		end
	end

	// long hold-off once mid-run so the token queue fills and chars.ready drops
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_if.ready <= 1'b0;
			holding      <= 1'b0;
			hold_done    <= 1'b0;
			take_gap = 0;
			hold_left = 0;
		end else begin
			if (!hold_done && beats_taken >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left = HOLD_CYCLES;
			end
			holding <= hold_left > 1;
			if (hold_left > 0) begin
				hold_left--;
				tok_if.ready <= 1'b0;
			end else begin
				if (take_gap == 0 && !calm && $urandom_range(0, 7) == 0)
					take_gap = $urandom_range(1, 17);
				if (take_gap > 0) begin
					take_gap--;
					tok_if.ready <= 1'b0;
				end else begin
					tok_if.ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : watch_tokens
		token_t want;
		if (arst_n && tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
			if (tok_expect.size() == 0) begin
				bad_tokens++;
				if (bad_tokens <= 10)
					$display("token %0d: unexpected, kind %0d len %0d text %h cut %b last %b",
						tok_seen, tok_if.token_kind, tok_if.token_length, tok_if.token_text,
						tok_if.text_cut, tok_if.last);
			end else begin
				want = tok_expect.pop_front();
				if (tok_if.token_kind !== want.kind || tok_if.token_length !== want.length ||
					tok_if.token_text !== want.text || tok_if.text_cut !== want.cut ||
					tok_if.last !== want.last) begin
					bad_tokens++;
					if (bad_tokens <= 10) begin
						$display("token %0d: want kind %0d len %0d text %h cut %b last %b",
							tok_seen, want.kind, want.length, want.text, want.cut, want.last);
						$display("token %0d:  got kind %0d len %0d text %h cut %b last %b",
							tok_seen, tok_if.token_kind, tok_if.token_length,
							tok_if.token_text, tok_if.text_cut, tok_if.last);
					end
				end
			end
			tok_seen++;
		end
	end

	initial begin
		arst_n              = 1'b0;
		src_if.valid        = 1'b0;
		src_if.in_char      = '0;
		src_if.end_of_input = 1'b0;
		tok_if.ready        = 1'b0;
		holding             = 1'b0;
		calm                = 1'b0;
		scan_state          = MODE_IDLE;
		pend_len            = '0;
		pend_text           = '0;
		bad_tokens          = 0;
		tok_seen            = 0;
		plan_directed();
		plan_random();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		do
			@(posedge clk);
		while (beat_plan.size() != 0 || src_if.valid || tok_expect.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tok_expect.size() != 0) begin
			$display("%0d tokens never arrived", tok_expect.size());
			bad_tokens += tok_expect.size();
		end
		if (bad_tokens == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/stc_pkg.sv
hw/rtl/stc_if.sv
hw/rtl/stc_scan.sv
hw/rtl/stc_result_fifo.sv
hw/rtl/source_char_tokenizer.sv
test/tb_top.sv
